// File: hw/rtl/hcit_pkg.sv
// shared constants, codes and types of the chained hash index table
`default_nettype none

package hcit_pkg;

   // transaction field widths
   localparam int unsigned CMD_W  = 2;
   localparam int unsigned KEY_W  = 31;
   localparam int unsigned SLOT_W = 10;
   localparam int unsigned POS_W  = 10;

   // configuration register
   localparam int unsigned CFG_W        = 12;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 12'd2039;

   // register indexes
   typedef enum logic [0:0] {
      REG_BUCKET_COUNT = 1'b0
   } reg_index_type;

   // default sizes
   localparam int unsigned DEF_SLOTS       = 1024;
   localparam int unsigned DEF_MAX_BUCKETS = 2048;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   // result source
   typedef enum logic [1:0] {
      RES_ZERO = 2'd0,
      RES_INS  = 2'd1,
      RES_HIT  = 2'd2
   } res_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic        capture;
      logic        clr_step;
      logic        ins_write;
      logic        walk_load;
      logic        walk_next;
      logic        res_set;
      res_sel_type res_sel;
      logic        rsp_load;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      cmd_type cmd;
      logic    mod_done;
      logic    clr_last;
      logic    head_valid;
      logic    key_match;
      logic    link_valid;
      logic    steps_last;
      logic    rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/hcit_ifs.sv
// request and response channel interfaces
`default_nettype none

interface hcit_req_if;
   logic                          valid;
   logic                          ready;
   logic [hcit_pkg::CMD_W-1:0]    cmd;
   logic [hcit_pkg::KEY_W-1:0]    key;
   logic [hcit_pkg::SLOT_W-1:0]   slot;

   modport source (output valid, cmd, key, slot, input ready);
   modport sink   (input valid, cmd, key, slot, output ready);
endinterface

interface hcit_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [hcit_pkg::POS_W-1:0]    position;

   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hcit_mod.sv
// iterative remainder unit, one dividend bit per cycle
`default_nettype none

module hcit_mod #(
   parameter int unsigned DW = 31,
   parameter int unsigned NW = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [NW-1:0] divisor,
   output logic               done,
   output logic [NW-1:0]      rem
);

   localparam int unsigned CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [NW-1:0] div_ff, div_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW:0]   trial;
   logic [NW:0]   diff;

   // one restoring step
   always_comb begin
      trial = {rem_ff, quo_ff[DW-1]};
      diff  = trial - {1'b0, div_ff};
   end

   // next state
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CW'(DW);
         quo_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, div_ff}) ? diff[NW-1:0] : trial[NW-1:0];
         quo_in = {quo_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

// File: hw/rtl/hcit_dp.sv
// datapath: bucket head memory, slot memories, chain walk and result registers
`default_nettype none

module hcit_dp #(
   parameter int unsigned SLOTS       = hcit_pkg::DEF_SLOTS,
   parameter int unsigned MAX_BUCKETS = hcit_pkg::DEF_MAX_BUCKETS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hcit_pkg::ctrl_cmd_type        ctl,
   output hcit_pkg::dp_status_type            st,
   input  wire logic [hcit_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [hcit_pkg::KEY_W-1:0]    req_key,
   input  wire logic [hcit_pkg::SLOT_W-1:0]   req_slot,
   input  wire logic [hcit_pkg::CFG_W-1:0]    bucket_count,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [hcit_pkg::POS_W-1:0]         rsp_position
);

   localparam int unsigned SW  = $clog2(SLOTS);
   localparam int unsigned BW  = $clog2(MAX_BUCKETS);
   localparam int unsigned NW  = BW + 1;
   localparam int unsigned KW  = hcit_pkg::KEY_W;
   localparam int unsigned PW  = hcit_pkg::POS_W;

   // memories: head entries and link entries hold {valid, slot}
   logic [SW:0]   head_mem [MAX_BUCKETS];
   logic [KW-1:0] key_mem  [SLOTS];
   logic [SW:0]   link_mem [SLOTS];

   logic [hcit_pkg::CMD_W-1:0] cmd_ff;
   logic [KW-1:0]  key_ff;
   logic [hcit_pkg::SLOT_W-1:0] slot_ff;
   logic [SW:0]    head_q_ff;
   logic [KW-1:0]  key_q_ff;
   logic [SW:0]    link_q_ff;
   logic [SW-1:0]  cur_ff, cur_in;
   logic [SW-1:0]  steps_ff, steps_in;
   logic [BW-1:0]  clr_ff, clr_in;
   logic           clr_last;
   logic           res_found_ff;
   logic [PW-1:0]  res_pos_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_found_ff;
   logic [PW-1:0]  rsp_pos_ff;
   logic [NW-1:0]  eff_count;
   logic           key_done;
   logic [NW-1:0]  key_rem;
   logic [BW-1:0]  bucket;
   logic [SW-1:0]  slot_idx;
   logic [BW-1:0]  head_addr;
   logic           head_we;
   logic [SW:0]    head_wdata;

   // bucket count clamped to 1..MAX_BUCKETS
   always_comb begin
      if (bucket_count == '0) begin
         eff_count = NW'(1);
      end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
         eff_count = NW'(MAX_BUCKETS);
      end else begin
         eff_count = NW'(bucket_count);
      end
   end

   // key mod bucket count, started on capture
   hcit_mod #(.DW(KW), .NW(NW)) u_key_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.capture),
      .dividend (req_key),
      .divisor  (eff_count),
      .done     (key_done),
      .rem      (key_rem)
   );

   assign bucket   = key_rem[BW-1:0];
   // slot index wraps at the power-of-two slot count
   assign slot_idx = SW'(slot_ff);

   // captured transaction
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff  <= req_cmd;
         key_ff  <= req_key;
         slot_ff <= req_slot;
      end
   end

   // clearing sweep counter
   assign clr_last = (clr_ff == BW'(MAX_BUCKETS - 1));
   always_comb begin
      clr_in = clr_ff;
      if (ctl.clr_step) begin
         clr_in = clr_last ? '0 : clr_ff + 1'b1;
      end
   end

   // head memory write port
   always_comb begin
      head_we    = ctl.clr_step | ctl.ins_write;
      head_addr  = ctl.clr_step ? clr_ff : bucket;
      head_wdata = ctl.clr_step ? '0 : {1'b1, slot_idx};
   end

   // head memory, registered read at the current bucket
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_addr] <= head_wdata;
      end
      head_q_ff <= head_mem[bucket];
   end

   // slot memories, registered read at the walk pointer
   always_ff @(posedge clock) begin
      if (ctl.ins_write) begin
         key_mem[slot_idx]  <= key_ff;
         link_mem[slot_idx] <= head_q_ff;
      end
      key_q_ff  <= key_mem[cur_ff];
      link_q_ff <= link_mem[cur_ff];
   end

   // chain walk pointer and step count
   always_comb begin
      cur_in   = cur_ff;
      steps_in = steps_ff;
      if (ctl.walk_load) begin
         cur_in   = head_q_ff[SW-1:0];
         steps_in = '0;
      end else if (ctl.walk_next) begin
         cur_in   = link_q_ff[SW-1:0];
         steps_in = steps_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
   end

   // result held until the response register is free
   always_ff @(posedge clock) begin
      if (ctl.res_set) begin
         case (ctl.res_sel)
            hcit_pkg::RES_INS: begin
               res_found_ff <= 1'b0;
               res_pos_ff   <= PW'(slot_idx);
            end
            hcit_pkg::RES_HIT: begin
               res_found_ff <= 1'b1;
               res_pos_ff   <= PW'(cur_ff);
            end
            default: begin
               res_found_ff <= 1'b0;
               res_pos_ff   <= '0;
            end
         endcase
      end
   end

   // response output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_pos_ff   <= res_pos_ff;
      end
   end

   // status to controller
   always_comb begin
      st.cmd        = hcit_pkg::cmd_type'(cmd_ff);
      st.mod_done   = key_done;
      st.clr_last   = clr_last;
      st.head_valid = head_q_ff[SW];
      st.key_match  = (key_q_ff == key_ff);
      st.link_valid = link_q_ff[SW];
      st.steps_last = (steps_ff == SW'(SLOTS - 1));
      st.rsp_free   = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_pos_ff;

endmodule

`default_nettype wire

// File: hw/rtl/hcit_ctrl.sv
// controller state machine sequencing clear, insert and lookup
`default_nettype none

module hcit_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire hcit_pkg::dp_status_type st,
   output hcit_pkg::ctrl_cmd_type       ctl
);

   typedef enum logic [7:0] {
      S_INIT  = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_DIV   = 8'b0000_0100,
      S_CLEAR = 8'b0000_1000,
      S_HEAD  = 8'b0001_0000,
      S_SRD   = 8'b0010_0000,
      S_CMP   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      ctl         = '0;
      ctl.res_sel = hcit_pkg::RES_ZERO;
      req_ready   = 1'b0;
      case (state_ff)
         S_INIT: begin
            ctl.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_DIV;
            end
         end
         S_DIV: begin
            case (st.cmd)
               hcit_pkg::CMD_CLEAR: begin
                  state_in = S_CLEAR;
               end
               hcit_pkg::CMD_INSERT, hcit_pkg::CMD_LOOKUP: begin
                  if (st.mod_done) begin
                     state_in = S_HEAD;
                  end
               end
               default: begin
                  ctl.res_set = 1'b1;
                  state_in    = S_DONE;
               end
            endcase
         end
         S_CLEAR: begin
            ctl.clr_step = 1'b1;
            if (st.clr_last) begin
               ctl.res_set = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_HEAD: begin
            if (st.cmd == hcit_pkg::CMD_INSERT) begin
               ctl.ins_write = 1'b1;
               ctl.res_set   = 1'b1;
               ctl.res_sel   = hcit_pkg::RES_INS;
               state_in      = S_DONE;
            end else if (st.head_valid) begin
               ctl.walk_load = 1'b1;
               state_in      = S_SRD;
            end else begin
               ctl.res_set = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_SRD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (st.key_match) begin
               ctl.res_set = 1'b1;
               ctl.res_sel = hcit_pkg::RES_HIT;
               state_in    = S_DONE;
            end else if (!st.link_valid || st.steps_last) begin
               ctl.res_set = 1'b1;
               state_in    = S_DONE;
            end else begin
               ctl.walk_next = 1'b1;
               state_in      = S_SRD;
            end
         end
         S_DONE: begin
            if (st.rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/chained_hash_index_table_top.sv
// top level of the chained hash index table with its register port
`default_nettype none

// Chained hash index table: maps a 31-bit key to the slot it was stored at, with
// one bucket chain per (key mod bucket_count). Items are handled one at a time.
// Every insert or lookup first runs the key through a bit-serial remainder unit,
// then reads the bucket head: an insert then writes the slot and responds, and a
// lookup walks the chain with one slot memory read and compare per entry. A clear
// rewrites every bucket head, one per cycle. After reset a clearing pass over
// every bucket head runs before the first transaction is taken; register writes
// are accepted during it. A response waits in an output register until taken,
// and the next transaction can be accepted meanwhile.
module chained_hash_index_table_top #(
   parameter int unsigned SLOTS       = hcit_pkg::DEF_SLOTS,
   parameter int unsigned MAX_BUCKETS = hcit_pkg::DEF_MAX_BUCKETS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   hcit_req_if.sink                                 req_chan,
   hcit_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [hcit_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [hcit_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [hcit_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                     csr_pready
);

   hcit_pkg::ctrl_cmd_type  ctl;
   hcit_pkg::dp_status_type st;
   logic [hcit_pkg::CFG_W-1:0] bucket_count_ff;
   logic                       csr_wr;
   logic                       reg_hit;

   // register decode
   assign reg_hit    = (hcit_pkg::reg_index_type'(csr_paddr[2]) ==
                        hcit_pkg::REG_BUCKET_COUNT);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? hcit_pkg::CSR_DATA_W'(bucket_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= hcit_pkg::BUCKET_COUNT_RESET;
      end else if (csr_wr && reg_hit) begin
         bucket_count_ff <= csr_pwdata[hcit_pkg::CFG_W-1:0];
      end
   end

   hcit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .ctl       (ctl)
   );

   hcit_dp #(.SLOTS(SLOTS), .MAX_BUCKETS(MAX_BUCKETS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .st           (st),
      .req_cmd      (req_chan.cmd),
      .req_key      (req_chan.key),
      .req_slot     (req_chan.slot),
      .bucket_count (bucket_count_ff),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_found    (rsp_chan.found),
      .rsp_position (rsp_chan.position)
   );

   // one transaction in flight: no acceptance right after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("transaction accepted while another is in flight");

   // the response register is only loaded when free
   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> st.rsp_free)
      else $error("response overwritten before it was taken");

   // a register write lands in bucket_count
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && reg_hit) |=>
      (bucket_count_ff == $past(csr_pwdata[hcit_pkg::CFG_W-1:0])))
      else $error("bucket_count write lost");

endmodule

`default_nettype wire
